// File: rtl/core/halton_subpixel_jitter_core_macros.svh
// Assertion helpers for the jitter core. They compile away in synthesis.
`ifndef HALTON_SUBPIXEL_JITTER_CORE_MACROS_SVH
`define HALTON_SUBPIXEL_JITTER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define HSJ_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define HSJ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define HSJ_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`define HSJ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// File: rtl/core/hsj_pkg.sv
`timescale 1ns / 1ps

package hsj_pkg;

  // Fixed field widths
  localparam int SIZE_W      = 16;
  localparam int POS_W       = 16;
  localparam int OFFSET_W    = 24;
  localparam int CFG_INDEX_W = 1;

  localparam logic [SIZE_W-1:0] WIDTH_RESET  = 16'd1920;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = 16'd1080;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIGITS,
    ST_MULT,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  // Control shared by every cell of a divider row
  typedef struct packed {
    logic load;
    logic step;
  } cell_ctl_t;

endpackage

// File: rtl/core/hsj_cell.sv
`timescale 1ns / 1ps

// One bit slice of the restoring divider: holds a remainder bit and a
// divisor bit, takes the shifted remainder bit from its lower neighbor.
module hsj_cell
  import hsj_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      take,
  input  logic      load_rem,
  input  logic      load_div,
  input  logic      rem_in,
  input  logic      borrow_in,
  output logic      rem,
  output logic      borrow_out
);

  logic dvs;
  logic diff;

  // Full subtractor on the doubled remainder bit
  assign diff       = rem_in ^ dvs ^ borrow_in;
  assign borrow_out = (~rem_in & dvs) | (~(rem_in ^ dvs) & borrow_in);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rem <= load_rem;
      dvs <= load_div;
    end else if (ctl.step) begin
      rem <= take ? diff : rem_in;
    end
  end

endmodule

// File: rtl/core/hsj_div.sv
`timescale 1ns / 1ps

// Restoring divider built as a row of bit cells, one quotient bit per step.
// The dividend must be below the divisor.
module hsj_div
  import hsj_pkg::*;
#(
  parameter int DIV_W  = 35,
  parameter int QUOT_W = 23
) (
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [DIV_W-1:0]  dividend,
  input  logic [DIV_W-1:0]  divisor,
  output logic [QUOT_W-1:0] quotient
);

  localparam int CHAIN_W = DIV_W + 1;

  logic [CHAIN_W-1:0] rem;
  logic [CHAIN_W-1:0] rem_in;
  logic [CHAIN_W-1:0] load_rem;
  logic [CHAIN_W-1:0] load_div;
  logic [CHAIN_W:0]   borrow_c;
  logic               take;

  assign load_rem    = {1'b0, dividend};
  assign load_div    = {1'b0, divisor};
  assign rem_in      = {rem[CHAIN_W-2:0], 1'b0};
  assign borrow_c[0] = 1'b0;
  // No borrow out of the top: doubled remainder >= divisor
  assign take        = ~borrow_c[CHAIN_W];

  for (genvar i = 0; i < CHAIN_W; i++) begin : g_cell
    hsj_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .take       (take),
      .load_rem   (load_rem[i]),
      .load_div   (load_div[i]),
      .rem_in     (rem_in[i]),
      .borrow_in  (borrow_c[i]),
      .rem        (rem[i]),
      .borrow_out (borrow_c[i+1])
    );
  end

  // Quotient bits shift in MSB first
  always_ff @(posedge clk) begin
    if (ctl.step) begin
      quotient <= {quotient[QUOT_W-2:0], take};
    end
  end

endmodule

// File: rtl/core/halton_subpixel_jitter_core.sv
`timescale 1ns / 1ps
// Halton (bases 2 and 3) sub-pixel jitter generator.
// Input channel: sample_position with in_valid/in_ready; the sequence index
// used is sample_position + 1. Output channel: offset_x/offset_y (signed
// Q1.23) with out_valid/out_ready, one result per input transfer.
// Config port: cfg_we/cfg_index/cfg_data writes frame_width (index 0) or
// frame_height (index 1); a size of zero counts as one.
// The index n has 1 to INDEX_BITS+1 bits. The digit loop takes one base-2
// and one base-3 digit of the index per cycle until both are exhausted,
// ST_MULT then forms the divisors, and the two divider rows produce one
// quotient bit per cycle. One item is in flight at a time: a new item is
// taken only once the core is back in idle.
// A finished result sits in the output register; the core takes the next
// item while it waits. If the receiver stalls, the next result holds in
// the final state until the output register frees up.
// Reset returns to idle, empties the output register and loads the frame
// size registers with 1920 x 1080.
`include "halton_subpixel_jitter_core_macros.svh"

module halton_subpixel_jitter_core
  import hsj_pkg::*;
#(
  parameter int INDEX_BITS    = 16,
  parameter int FRACTION_BITS = 23
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_W-1:0]     cfg_index,
  input  logic [SIZE_W-1:0]          cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [POS_W-1:0]           sample_position,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [OFFSET_W-1:0] offset_x,
  output logic signed [OFFSET_W-1:0] offset_y
);

  localparam int N_W         = INDEX_BITS + 1;
  localparam int DEN2_W      = N_W + 1;
  localparam int DEN3_W      = N_W + 2;
  localparam int DIV_W       = DEN3_W + SIZE_W;
  localparam int RECIP_SHIFT = N_W + 1;
  localparam logic [63:0] RECIP_FULL = ((64'd1 << RECIP_SHIFT) + 64'd2) / 64'd3;
  localparam logic [N_W-1:0] RECIP = RECIP_FULL[N_W-1:0];
  localparam int SIGNED_W = (FRACTION_BITS + 1 > OFFSET_W) ? FRACTION_BITS + 1 : OFFSET_W;
  localparam int STEP_W   = $clog2(FRACTION_BITS);

  state_t state;
  state_t state_next;

  logic [SIZE_W-1:0] frame_width;
  logic [SIZE_W-1:0] frame_height;

  logic [N_W-1:0]    n2;
  logic [N_W-1:0]    n3;
  logic [N_W-1:0]    num2;
  logic [DEN2_W-1:0] den2;
  logic [DEN3_W-1:0] num3;
  logic [DEN3_W-1:0] den3;
  logic              neg_x;
  logic              neg_y;
  logic [STEP_W-1:0] step_cnt;

  logic [N_W-1:0]    n_init;
  logic [2*N_W-1:0]  prod3;
  logic [N_W-1:0]    q3;
  logic [N_W:0]      q3_triple;
  logic [1:0]        digit3;
  logic [DEN3_W-1:0] num3_next;
  logic [DEN3_W-1:0] den3_x3;
  logic              digits_last;

  logic [SIZE_W-1:0]        size_x;
  logic [SIZE_W-1:0]        size_y;
  logic [DEN2_W-1:0]        twice2;
  logic [DEN2_W-1:0]        mag2;
  logic                     neg2;
  logic [DEN3_W:0]          twice3;
  logic [DEN3_W:0]          mag3_wide;
  logic [DEN3_W-1:0]        mag3;
  logic                     neg3;
  logic [DEN2_W+SIZE_W-1:0] divisor_x;
  logic [DIV_W-1:0]         divisor_y;

  cell_ctl_t                ctl;
  logic [FRACTION_BITS-1:0] quo_x;
  logic [FRACTION_BITS-1:0] quo_y;
  logic [SIGNED_W-1:0]      signed_x;
  logic [SIGNED_W-1:0]      signed_y;
  logic                     out_free;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_FRAME_WIDTH:  frame_width  <= cfg_data;
        CFG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequence index n = masked position + 1
  assign n_init = {1'b0, INDEX_BITS'(sample_position)} + N_W'(1);

  // Base-3 digit: n / 3 by reciprocal multiply, remainder from n - 3q
  assign prod3       = n3 * RECIP;
  assign q3          = {1'b0, prod3[2*N_W-1:RECIP_SHIFT]};
  assign q3_triple   = {q3, 1'b0} + {1'b0, q3};
  assign digit3      = n3[1:0] - q3_triple[1:0];
  assign num3_next   = {num3[DEN3_W-2:0], 1'b0} + num3 + DEN3_W'(digit3);
  assign den3_x3     = {den3[DEN3_W-2:0], 1'b0} + den3;
  assign digits_last = (n2[N_W-1:1] == '0) && (q3 == '0);

  // Digit loop registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      n2   <= n_init;
      n3   <= n_init;
      num2 <= '0;
      den2 <= DEN2_W'(1);
      num3 <= '0;
      den3 <= DEN3_W'(1);
    end else if (state == ST_DIGITS) begin
      if (n2 != '0) begin
        n2   <= n2 >> 1;
        num2 <= {num2[N_W-2:0], n2[0]};
        den2 <= {den2[DEN2_W-2:0], 1'b0};
      end
      if (n3 != '0) begin
        n3   <= q3;
        num3 <= num3_next;
        den3 <= den3_x3;
      end
    end
  end

  // Signed numerator 2*num - den and divisor den * size
  assign size_x    = (frame_width  == '0) ? SIZE_W'(1) : frame_width;
  assign size_y    = (frame_height == '0) ? SIZE_W'(1) : frame_height;
  assign twice2    = {num2, 1'b0};
  assign neg2      = twice2 < den2;
  assign mag2      = neg2 ? (den2 - twice2) : (twice2 - den2);
  assign twice3    = {num3, 1'b0};
  assign neg3      = twice3 < {1'b0, den3};
  assign mag3_wide = neg3 ? ({1'b0, den3} - twice3) : (twice3 - {1'b0, den3});
  assign mag3      = mag3_wide[DEN3_W-1:0];
  assign divisor_x = den2 * size_x;
  assign divisor_y = den3 * size_y;

  always_ff @(posedge clk) begin
    if (state == ST_MULT) begin
      neg_x <= neg2;
      neg_y <= neg3;
    end
  end

  // Divider step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      step_cnt <= '0;
    end else if (state == ST_MULT) begin
      step_cnt <= '0;
    end else if (state == ST_DIVIDE) begin
      step_cnt <= step_cnt + STEP_W'(1);
    end
  end

  always_comb begin
    ctl.load = (state == ST_MULT);
    ctl.step = (state == ST_DIVIDE);
  end

  hsj_div #(
    .DIV_W  (DIV_W),
    .QUOT_W (FRACTION_BITS)
  ) u_div_x (
    .clk      (clk),
    .ctl      (ctl),
    .dividend (DIV_W'(mag2)),
    .divisor  (DIV_W'(divisor_x)),
    .quotient (quo_x)
  );

  hsj_div #(
    .DIV_W  (DIV_W),
    .QUOT_W (FRACTION_BITS)
  ) u_div_y (
    .clk      (clk),
    .ctl      (ctl),
    .dividend (DIV_W'(mag3)),
    .divisor  (divisor_y),
    .quotient (quo_y)
  );

  // Sign and truncate to the field width
  assign signed_x = neg_x ? (SIGNED_W'(0) - SIGNED_W'(quo_x)) : SIGNED_W'(quo_x);
  assign signed_y = neg_y ? (SIGNED_W'(0) - SIGNED_W'(quo_y)) : SIGNED_W'(quo_y);
  assign out_free = !out_valid || out_ready;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        if (digits_last) begin
          state_next = ST_MULT;
        end
      end
      ST_MULT: begin
        state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (step_cnt == STEP_W'(FRACTION_BITS - 1)) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      offset_x <= $signed(signed_x[OFFSET_W-1:0]);
      offset_y <= $signed(signed_y[OFFSET_W-1:0]);
    end
  end

  // Checks
  `HSJ_ASSERT_NEXT(a_accept_loads_index, clk, rst, in_valid && in_ready,
                   n2 == n3 && n2 != '0, "index not loaded on input transfer")
  `HSJ_ASSERT_IMPLIES(a_mag_below_den, clk, rst, state == ST_MULT,
                      mag2 < den2 && mag3 < den3,
                      "numerator magnitude not below denominator")
  `HSJ_ASSERT_IMPLIES(a_digits_drained, clk, rst, state == ST_FINISH,
                      n2 == '0 && n3 == '0, "digit loop not drained at finish")
  `HSJ_ASSERT_IMPLIES(a_out_from_finish, clk, rst, $rose(out_valid),
                      $past(state) == ST_FINISH, "result shown outside finish state")

endmodule

// File: tb/sv/tb_halton_subpixel_jitter_core.sv
`timescale 1ns / 1ps

module tb_halton_subpixel_jitter_core;
  import hsj_pkg::*;

  localparam int INDEX_BITS       = 16;
  localparam int FRACTION_BITS    = 23;
  localparam int CYCLE_LIMIT      = 400000;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES    = 64;
  localparam int PHASES           = 10;
  localparam int ITEMS_PER_PHASE  = 125;

  // Directed plan: either an item or a new frame size
  typedef enum logic {
    ROW_ITEM,
    ROW_SIZE
  } plan_kind_t;

  typedef struct packed {
    plan_kind_t          kind;
    logic [POS_W-1:0]    a;      // sample position, or frame width
    logic [SIZE_W-1:0]   b;      // frame height
    logic                typed;  // expected pair given below
    logic [OFFSET_W-1:0] x;
    logic [OFFSET_W-1:0] y;
  } plan_row_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] x;
    logic [OFFSET_W-1:0] y;
  } jitter_pair_t;

  logic                       clk;
  logic                       rst = 1'b1;
  logic                       cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0]     cfg_index = CFG_FRAME_WIDTH;
  logic [SIZE_W-1:0]          cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [POS_W-1:0]           sample_position = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [OFFSET_W-1:0] offset_x;
  logic signed [OFFSET_W-1:0] offset_y;

  // Predictor copy of the frame size registers
  logic [SIZE_W-1:0] frame_w = WIDTH_RESET;
  logic [SIZE_W-1:0] frame_h = HEIGHT_RESET;

  jitter_pair_t pending_jitter[$];
  int           error_count = 0;
  int           cycle_count = 0;
  bit           no_idle = 1'b0;
  bit           long_hold = 1'b0;

  plan_row_t directed_plan [26] = '{
    // reset sizes 1920 x 1080
    '{ROW_ITEM, 16'd0,     16'd0,     1'b0, 24'd0, 24'd0},
    '{ROW_ITEM, 16'd1,     16'd0,     1'b0, 24'd0, 24'd0},
    '{ROW_ITEM, 16'd2,     16'd0,     1'b0, 24'd0, 24'd0},
    '{ROW_ITEM, 16'd3,     16'd0,     1'b0, 24'd0, 24'd0},
    '{ROW_ITEM, 16'hFFFF,  16'd0,     1'b0, 24'd0, 24'd0},
    '{ROW_ITEM, 16'hFFFE,  16'd0,     1'b0, 24'd0, 24'd0},
    '{ROW_ITEM, 16'h5555,  16'd0,     1'b0, 24'd0, 24'd0},
    '{ROW_ITEM, 16'hAAAA,  16'd0,     1'b0, 24'd0, 24'd0},
    '{ROW_ITEM, 16'h8000,  16'd0,     1'b0, 24'd0, 24'd0},
    '{ROW_ITEM, 16'h7FFF,  16'd0,     1'b0, 24'd0, 24'd0},
    // unit frame: offsets are plain 2h-1; index 1 sits on the midpoint in x
    '{ROW_SIZE, 16'd1,     16'd1,     1'b0, 24'd0, 24'd0},
    '{ROW_ITEM, 16'd0,     16'd0,     1'b1, 24'd0, 24'(-2796202)},
    '{ROW_ITEM, 16'd1,     16'd0,     1'b1, 24'(-4194304), 24'd2796202},
    '{ROW_ITEM, 16'd2,     16'd0,     1'b1, 24'd4194304, 24'(-6524472)},
    '{ROW_ITEM, 16'hFFFF,  16'd0,     1'b0, 24'd0, 24'd0},
    '{ROW_ITEM, 16'd59048, 16'd0,     1'b0, 24'd0, 24'd0},
    // largest frame
    '{ROW_SIZE, 16'hFFFF,  16'hFFFF,  1'b0, 24'd0, 24'd0},
    '{ROW_ITEM, 16'd0,     16'd0,     1'b0, 24'd0, 24'd0},
    '{ROW_ITEM, 16'hFFFF,  16'd0,     1'b0, 24'd0, 24'd0},
    '{ROW_ITEM, 16'd12345, 16'd0,     1'b0, 24'd0, 24'd0},
    // zero size counts as one
    '{ROW_SIZE, 16'd0,     16'd0,     1'b0, 24'd0, 24'd0},
    '{ROW_ITEM, 16'd0,     16'd0,     1'b1, 24'd0, 24'(-2796202)},
    '{ROW_ITEM, 16'd1,     16'd0,     1'b1, 24'(-4194304), 24'd2796202},
    // mixed extremes
    '{ROW_SIZE, 16'd1,     16'hFFFF,  1'b0, 24'd0, 24'd0},
    '{ROW_ITEM, 16'd3,     16'd0,     1'b0, 24'd0, 24'd0},
    '{ROW_ITEM, 16'd40000, 16'd0,     1'b0, 24'd0, 24'd0}
  };

  halton_subpixel_jitter_core u_top (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .sample_position (sample_position),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .offset_x        (offset_x),
    .offset_y        (offset_y)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Radical inverse of n in the given base, mapped to (2h-1)/size in Q1.23
  function automatic logic [OFFSET_W-1:0] halton_offset(longint unsigned n,
                                                        int unsigned base,
                                                        logic [SIZE_W-1:0] size);
    longint unsigned mirrored = 0;
    longint unsigned scale = 1;
    longint unsigned rest = n;
    longint unsigned twice;
    longint unsigned mag;
    longint unsigned quo;
    bit              below;
    do begin
      mirrored = mirrored * base + (rest % base);
      scale    = scale * base;
      rest     = rest / base;
    end while (rest != 0);
    twice = mirrored * 2;
    below = twice < scale;
    mag   = below ? (scale - twice) : (twice - scale);
    quo   = (mag << FRACTION_BITS) / (scale * ((size == 0) ? 1 : size));
    if (below) quo = ~quo + 1;
    return quo[OFFSET_W-1:0];
  endfunction

  function automatic jitter_pair_t predict_jitter(logic [POS_W-1:0] pos);
    longint unsigned n;
    jitter_pair_t    pair;
    n      = (longint'(pos) & ((64'd1 << INDEX_BITS) - 1)) + 1;
    pair.x = halton_offset(n, 2, frame_w);
    pair.y = halton_offset(n, 3, frame_h);
    return pair;
  endfunction

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 5);
  endfunction

  // Mostly uniform, with weight on small indexes and digit-count boundaries
  function automatic logic [POS_W-1:0] random_position();
    int pick;
    int p;
    pick = $urandom_range(0, 7);
    case (pick)
      0, 1: return POS_W'($urandom_range(0, 63));
      2: begin
        p = 1 << $urandom_range(1, 16);
        return POS_W'(p - int'($urandom_range(1, 2)));
      end
      3: begin
        p = 3;
        repeat ($urandom_range(0, 9)) p = p * 3;
        return POS_W'(p - int'($urandom_range(1, 2)));
      end
      default: return POS_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [SIZE_W-1:0] random_size();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return SIZE_W'(1);
      2: return '1;
      3: return SIZE_W'($urandom_range(1, 16));
      4: return ($urandom_range(0, 1) != 0) ? WIDTH_RESET : HEIGHT_RESET;
      default: return SIZE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic report_error(string msg);
    error_count++;
    $display("%0t ns: %s", $time, msg);
  endtask

  // Offer one position and hold it until the transfer
  task automatic offer_position(logic [POS_W-1:0] pos, logic typed,
                                logic [OFFSET_W-1:0] typed_x,
                                logic [OFFSET_W-1:0] typed_y);
    jitter_pair_t want;
    int           gap;
    if (typed) begin
      want.x = typed_x;
      want.y = typed_y;
    end else begin
      want = predict_jitter(pos);
    end
    gap = draw_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    sample_position <= pos;
    do @(posedge clk); while (!in_ready);
    pending_jitter.push_back(want);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_jitter.size() != 0) @(posedge clk);
  endtask

  // Both registers, written back to back while nothing is in flight
  task automatic set_frame_size(logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FRAME_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= CFG_FRAME_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_we  <= 1'b0;
    frame_w  = w;
    frame_h  = h;
  endtask

  // Result side: random stalls, one long hold on request, check each transfer
  initial begin
    jitter_pair_t want;
    int           gap;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end
      gap = draw_gap();
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (pending_jitter.size() == 0) begin
        report_error($sformatf("unexpected result x=%0d y=%0d", offset_x, offset_y));
      end else begin
        want = pending_jitter.pop_front();
        if (offset_x !== want.x)
          report_error($sformatf("offset_x got %0d, expected %0d",
                                 offset_x, $signed(want.x)));
        if (offset_y !== want.y)
          report_error($sformatf("offset_y got %0d, expected %0d",
                                 offset_y, $signed(want.y)));
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Stimulus: directed plan, then random phases with fresh frame sizes
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_plan[r]) begin
      if (directed_plan[r].kind == ROW_SIZE)
        set_frame_size(directed_plan[r].a, directed_plan[r].b);
      else
        offer_position(directed_plan[r].a, directed_plan[r].typed,
                       directed_plan[r].x, directed_plan[r].y);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      set_frame_size(random_size(), random_size());
      no_idle = (ph == 5) || ($urandom_range(0, 3) == 0);
      // stall the result side long enough to back up the input
      if (ph == 2) long_hold = 1'b1;
      repeat (ITEMS_PER_PHASE) offer_position(random_position(), 1'b0, '0, '0);
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: halton_subpixel_jitter_core.f
+incdir+rtl/core
rtl/core/hsj_pkg.sv
rtl/core/hsj_cell.sv
rtl/core/hsj_div.sv
rtl/core/halton_subpixel_jitter_core.sv
tb/sv/tb_halton_subpixel_jitter_core.sv
